### rtl/sacl_pkg.sv
// Shared types, codes and default sizes for the set-associative cache LRU simulator.
package sacl_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_BITS    = 32;

    localparam int STAMP_W      = 32;
    localparam int TOTAL_W      = 32;
    localparam int SET_BITS_W   = 3;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int OPCODE_W     = 2;
    localparam int OUTCOME_W    = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_FETCH  = 2'd3
    } t_opcode;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_COLD  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_WAYS       = 2'd1,
        CFG_BLOCK_BITS = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic read;
        logic match;
        logic scan;
        logic commit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic in_fetch;
        logic in_modify;
        logic hit;
        logic empty;
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/set_assoc_cache_lru_sim.sv
// Load, store or hit/fill: item accepted in idle, then read, match and commit states; the result
// is registered at commit, and the block is ready again on its return to idle. An eviction adds
// a scan state that walks the ways in use of the set row for the oldest stamp. A modify runs the
// lookup twice, plus the scan if the first lookup evicts. An instruction fetch is taken in idle
// and gives no result; a stalled result holds commit. Reset is synchronous and active low;
// afterwards a clearing pass empties every set, and no item is accepted until it has finished.
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS    = sacl_pkg::DEF_ADDR_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sacl_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [ADDR_BITS-1:0]              i_address,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sacl_pkg::OUTCOME_W-1:0]    o_outcome,
    output logic                              o_last_of_run,
    output logic [sacl_pkg::TOTAL_W-1:0]      o_hit_total,
    output logic [sacl_pkg::TOTAL_W-1:0]      o_miss_total,
    output logic [sacl_pkg::TOTAL_W-1:0]      o_eviction_total
);
    import sacl_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sacl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    sacl_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_address        (i_address),
        .i_stall          (i_stall),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_outcome        (o_outcome),
        .o_last_of_run    (o_last_of_run),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    // A data access keeps the block busy on the following cycle.
    a_access_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_opcode != OP_FETCH) |=> o_stall)
        else $error("data access accepted but block ready again at once");

    // A result appears only from a commit of the sequencer.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.commit))
        else $error("result valid without a commit");

    // After the first half of a modify the second lookup is still to come.
    a_modify_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.commit && !w_cmd.last) |=> o_stall)
        else $error("block ready between the two lookups of a modify");

    // No item enters while the clearing pass is running.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_wr |-> (o_stall && !w_cmd.accept))
        else $error("item accepted during the clearing pass");

endmodule

### rtl/sacl_ctrl.sv
// Sequencing state machine for the cache simulator: clearing pass, lookup steps and commit.
module sacl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sacl_pkg::t_dp_status  i_status,
    output sacl_pkg::t_dp_cmd     o_cmd
);
    import sacl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MATCH,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_modify;
    logic   r_second;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear_wr = (r_state == S_CLEAR);
        o_cmd.accept   = (r_state == S_IDLE) && i_valid;
        o_cmd.read     = (r_state == S_READ);
        o_cmd.match    = (r_state == S_MATCH);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.commit   = (r_state == S_COMMIT) && i_status.out_free;
        // Only the first lookup of a modify is not the last result of its item.
        o_cmd.last     = !(r_modify && !r_second);
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_modify <= 1'b0;
            r_second <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_status.clear_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && !i_status.in_fetch) begin
                        r_state  <= S_READ;
                        r_modify <= i_status.in_modify;
                        r_second <= 1'b0;
                    end
                end
                S_READ: begin
                    r_state <= S_MATCH;
                end
                S_MATCH: begin
                    if (i_status.hit || i_status.empty) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_status.scan_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (i_status.out_free) begin
                        if (r_modify && !r_second) begin
                            r_second <= 1'b1;
                            r_state  <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

### rtl/sacl_dp.sv
// Datapath of the cache simulator: configuration, set memories, way search, counters, result.
module sacl_dp #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS    = sacl_pkg::DEF_ADDR_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [sacl_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [ADDR_BITS-1:0]              i_address,
    input  logic                              i_stall,
    input  sacl_pkg::t_dp_cmd                 i_cmd,
    output sacl_pkg::t_dp_status              o_status,
    output logic                              o_valid,
    output logic [sacl_pkg::OUTCOME_W-1:0]    o_outcome,
    output logic                              o_last_of_run,
    output logic [sacl_pkg::TOTAL_W-1:0]      o_hit_total,
    output logic [sacl_pkg::TOTAL_W-1:0]      o_miss_total,
    output logic [sacl_pkg::TOTAL_W-1:0]      o_eviction_total
);
    import sacl_pkg::*;

    localparam int IDX_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH   = 1 << IDX_W;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int WC_W    = (WCNT_W > WAYS_W) ? WCNT_W : WAYS_W;
    localparam int SB_W    = SET_BITS_W + 1;
    localparam int SHIFT_W = ((SB_W > BLOCK_BITS_W) ? SB_W : BLOCK_BITS_W) + 1;

    // Configuration registers.
    logic [SET_BITS_W-1:0]   r_set_bits;
    logic [WAYS_W-1:0]       r_ways;
    logic [BLOCK_BITS_W-1:0] r_block_bits;

    // Set memories, one row per set.
    logic [MAX_WAYS-1:0]                     mem_valid [DEPTH];
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]      mem_tag   [DEPTH];
    logic [MAX_WAYS-1:0][STAMP_W-1:0]        mem_stamp [DEPTH];

    logic [MAX_WAYS-1:0]                     r_rd_valid;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]      r_rd_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]        r_rd_stamp;

    logic [IDX_W-1:0]     r_clr_idx;
    logic [IDX_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic [WAY_W-1:0]     r_way;
    t_outcome             r_outcome;
    logic [STAMP_W-1:0]   r_best_age;
    logic [WCNT_W-1:0]    r_scan;

    logic [STAMP_W-1:0]   r_time;
    logic [TOTAL_W-1:0]   r_hit_count;
    logic [TOTAL_W-1:0]   r_miss_count;
    logic [TOTAL_W-1:0]   r_evict_count;

    logic                 r_out_valid;
    t_outcome             r_out_outcome;
    logic                 r_out_last;

    logic [SB_W-1:0]      eff_sb;
    logic [WC_W-1:0]      ways_ext;
    logic [WCNT_W-1:0]    eff_ways;
    logic [SHIFT_W-1:0]   tag_shift;
    logic [ADDR_BITS-1:0] addr_shift;
    logic [IDX_W-1:0]     set_mask;
    logic [IDX_W-1:0]     n_set;
    logic [ADDR_BITS-1:0] n_tag;

    logic [MAX_WAYS-1:0]  hit_vec;
    logic [MAX_WAYS-1:0]  empty_vec;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     empty_way;
    logic                 scan_done;
    logic [STAMP_W-1:0]   scan_age;
    logic                 out_free;

    logic                                wr_en;
    logic [IDX_W-1:0]                    wr_addr;
    logic [MAX_WAYS-1:0]                 wr_valid;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  wr_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]    wr_stamp;

    // Effective geometry: set bits clamp to the maximum, ways clamp into one..maximum.
    always_comb begin
        if ({1'b0, r_set_bits} > SB_W'(MAX_SET_BITS)) begin
            eff_sb = SB_W'(MAX_SET_BITS);
        end else begin
            eff_sb = {1'b0, r_set_bits};
        end
        ways_ext = WC_W'(r_ways);
        if (ways_ext == '0) begin
            eff_ways = WCNT_W'(1);
        end else if (ways_ext > WC_W'(MAX_WAYS)) begin
            eff_ways = WCNT_W'(MAX_WAYS);
        end else begin
            eff_ways = WCNT_W'(ways_ext);
        end
    end

    // Address split of the incoming item. A tag shift past the address width yields zero.
    always_comb begin
        addr_shift = i_address >> r_block_bits;
        set_mask   = ~({IDX_W{1'b1}} << eff_sb);
        n_set      = addr_shift[IDX_W-1:0] & set_mask;
        tag_shift  = SHIFT_W'(eff_sb) + SHIFT_W'(r_block_bits);
        n_tag      = i_address >> tag_shift;
    end

    // Hit and empty-way search over the ways in use; lowest way wins.
    always_comb begin
        hit_way   = '0;
        empty_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            hit_vec[w]   = (WCNT_W'(w) < eff_ways) && r_rd_valid[w] && (r_rd_tag[w] == r_tag);
            empty_vec[w] = (WCNT_W'(w) < eff_ways) && !r_rd_valid[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (empty_vec[w]) begin
                empty_way = WAY_W'(w);
            end
        end
    end

    assign scan_done = (r_scan >= eff_ways);
    assign scan_age  = r_time - r_rd_stamp[r_scan[WAY_W-1:0]];
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        o_status            = '0;
        o_status.clear_done = (r_clr_idx == {IDX_W{1'b1}});
        o_status.in_fetch   = (i_opcode == OP_FETCH);
        o_status.in_modify  = (i_opcode == OP_MODIFY);
        o_status.hit        = |hit_vec;
        o_status.empty      = |empty_vec;
        o_status.scan_done  = scan_done;
        o_status.out_free   = out_free;
    end

    // Row write: the clearing pass empties a row, a commit updates one way of the row read.
    always_comb begin
        wr_en    = i_cmd.clear_wr || i_cmd.commit;
        wr_addr  = r_set;
        wr_valid = r_rd_valid;
        wr_tag   = r_rd_tag;
        wr_stamp = r_rd_stamp;
        if (i_cmd.clear_wr) begin
            wr_addr  = r_clr_idx;
            wr_valid = '0;
            wr_tag   = '1;
            wr_stamp = '0;
        end else begin
            wr_valid[r_way] = 1'b1;
            wr_tag[r_way]   = r_tag;
            wr_stamp[r_way] = r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_valid[wr_addr] <= wr_valid;
            mem_tag[wr_addr]   <= wr_tag;
            mem_stamp[wr_addr] <= wr_stamp;
        end
        if (i_cmd.read) begin
            r_rd_valid <= mem_valid[r_set];
            r_rd_tag   <= mem_tag[r_set];
            r_rd_stamp <= mem_stamp[r_set];
        end
    end

    // Lookup payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set <= n_set;
            r_tag <= n_tag;
        end
        if (i_cmd.match) begin
            if (|hit_vec) begin
                r_way     <= hit_way;
                r_outcome <= OUT_HIT;
            end else if (|empty_vec) begin
                r_way     <= empty_way;
                r_outcome <= OUT_COLD;
            end else begin
                r_way     <= '0;
                r_outcome <= OUT_EVICT;
            end
            r_best_age <= r_time - r_rd_stamp[0];
            r_scan     <= WCNT_W'(1);
        end else if (i_cmd.scan && !scan_done) begin
            // Strictly older only, so ties keep the lower way.
            if (scan_age > r_best_age) begin
                r_best_age <= scan_age;
                r_way      <= r_scan[WAY_W-1:0];
            end
            r_scan <= r_scan + WCNT_W'(1);
        end
        if (i_cmd.commit) begin
            r_out_outcome <= r_outcome;
            r_out_last    <= i_cmd.last;
        end
    end

    // Control state: configuration, clearing index, time and totals, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_ways        <= WAYS_W'(1);
            r_block_bits  <= '0;
            r_clr_idx     <= '0;
            r_time        <= '0;
            r_hit_count   <= '0;
            r_miss_count  <= '0;
            r_evict_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                    CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLOCK_BITS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_wr) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (i_cmd.commit) begin
                r_time <= r_time + STAMP_W'(1);
                case (r_outcome)
                    OUT_HIT: begin
                        r_hit_count <= r_hit_count + TOTAL_W'(1);
                    end
                    OUT_COLD: begin
                        r_miss_count <= r_miss_count + TOTAL_W'(1);
                    end
                    default: begin
                        r_miss_count  <= r_miss_count + TOTAL_W'(1);
                        r_evict_count <= r_evict_count + TOTAL_W'(1);
                    end
                endcase
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The totals only move on a commit, which waits for the previous result to leave.
    assign o_valid          = r_out_valid;
    assign o_outcome        = r_out_outcome;
    assign o_last_of_run    = r_out_last;
    assign o_hit_total      = r_hit_count;
    assign o_miss_total     = r_miss_count;
    assign o_eviction_total = r_evict_count;

endmodule
